// ===== rtl/hctp_pkg.sv =====
// Shared types, codes and constants of the height/color terrain packer.
package hctp_pkg;

    localparam int PIX_W      = 8;
    localparam int COLOR_W    = 3;
    localparam int DIV_STEPS  = PIX_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] FULL_SCALE  = 8'd255;
    localparam logic [PIX_W-1:0] HEIGHT_MASK = 8'hF8;

    // Item operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;     // latch an accepted input beat
        logic step;     // run one divider iteration
        logic publish;  // load the result register
    } hctp_cmd_t;

endpackage

// ===== rtl/hctp_datapath.sv =====
// Datapath: running peak, restoring divider and result register.
module hctp_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  hctp_pkg::hctp_cmd_t              cmd,
    input  logic                             operation,
    input  logic                             frame_start,
    input  logic [hctp_pkg::PIX_W-1:0]       height_value,
    input  logic [hctp_pkg::PIX_W-1:0]       color_value,
    output logic [hctp_pkg::PIX_W-1:0]       packed_byte,
    output logic [hctp_pkg::PIX_W-1:0]       height_level,
    output logic [hctp_pkg::COLOR_W-1:0]     color_level
);
    import hctp_pkg::*;

    logic [PIX_W-1:0]     peak_reg,  peak_next;
    logic [2*PIX_W-1:0]   acc_reg,   acc_next;
    logic [PIX_W-1:0]     div_reg;
    logic                 zero_reg;
    logic                 sat_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [PIX_W-1:0]     hl_reg;
    logic [COLOR_W-1:0]   cl_reg;

    logic [PIX_W-1:0]     peak_base;
    logic [2*PIX_W-1:0]   product;
    logic [PIX_W:0]       trial;
    logic                 fits;
    logic [PIX_W:0]       diff;
    logic [PIX_W-1:0]     quot;

    // Track the running maximum height on measure beats
    always_comb
    begin
        peak_base = frame_start ? '0 : peak_reg;
        peak_next = peak_reg;
        if (cmd.take && operation == OP_MEASURE && height_value > peak_base)
            peak_next = height_value;
        else if (cmd.take && operation == OP_MEASURE)
            peak_next = peak_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peak_reg <= '0;
        else
            peak_reg <= peak_next;
    end

    // height * 255 as (height << 8) - height
    assign product = {height_value, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, height_value};

    // One restoring division step: shift in a dividend bit, trial subtract
    always_comb
    begin
        trial = {acc_reg[2*PIX_W-1:PIX_W], acc_reg[PIX_W-1]};
        fits  = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
        acc_next = acc_reg;
        if (cmd.take)
            acc_next = product;
        else if (cmd.step)
            acc_next = {(fits ? diff[PIX_W-1:0] : trial[PIX_W-1:0]),
                        acc_reg[PIX_W-2:0], fits};
    end

    // Latch convert operands; zero peak and overrange heights bypass the quotient
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.take)
        begin
            div_reg   <= peak_reg;
            zero_reg  <= (peak_reg == '0);
            sat_reg   <= (height_value > peak_reg);
            color_reg <= color_value[PIX_W-1 -: COLOR_W];
        end
    end

    always_comb
    begin
        if (zero_reg)
            quot = '0;
        else if (sat_reg)
            quot = FULL_SCALE;
        else
            quot = acc_reg[PIX_W-1:0];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            hl_reg <= quot & HEIGHT_MASK;
            cl_reg <= color_reg;
        end
    end

    assign height_level = hl_reg;
    assign color_level  = cl_reg;
    assign packed_byte  = hl_reg | {{(PIX_W-COLOR_W){1'b0}}, cl_reg};

endmodule

// ===== rtl/hctp_ctrl.sv =====
// Controller: accept handshake, divider sequencing and output valid.
module hctp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hctp_pkg::hctp_cmd_t  cmd
);
    import hctp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg,   cnt_next;
    logic                  ovalid_reg, ovalid_next;
    logic                  accept;
    logic                  out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_free  = !ovalid_reg || out_ready;

    // Sequence: accept, eight divider steps, then wait for the result register
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.take    = accept;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_CONVERT)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Set valid on publish, drop it when the beat is taken
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.publish)
            ovalid_next = 1'b1;
        else if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_CONVERT) |-> ##9 (state_reg == ST_HOLD))
        else $error("divider did not finish in eight steps");

    a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid)
        else $error("published result not shown as valid");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (state_reg == ST_DIV))
        else $error("step counter running outside divide state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!ovalid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule

// ===== rtl/height_color_terrain_packer_core.sv =====
// Height/color terrain packer: measure peak height, then pack normalized pixels.
// A measure beat (operation 0) updates the running peak height, cleared
// first when frame_start is set, and produces no result. A convert beat
// (operation 1) produces one result: its operands are latched, the single
// restoring divider runs eight iterations to form floor(height*255/peak),
// and the output register is loaded. Input is taken only between convert
// beats; a finished result waits in the output register while the next
// beat is accepted. A zero peak gives height level 0, and a height above
// the peak gives height level 248.
module height_color_terrain_packer_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic                               frame_start,
    input  logic [hctp_pkg::PIX_W-1:0]         height_value,
    input  logic [hctp_pkg::PIX_W-1:0]         color_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hctp_pkg::PIX_W-1:0]         packed_byte,
    output logic [hctp_pkg::PIX_W-1:0]         height_level,
    output logic [hctp_pkg::COLOR_W-1:0]       color_level
);
    import hctp_pkg::*;

    hctp_cmd_t cmd;

    hctp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    hctp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .frame_start  (frame_start),
        .height_value (height_value),
        .color_value  (color_value),
        .packed_byte  (packed_byte),
        .height_level (height_level),
        .color_level  (color_level)
    );

endmodule
